/* rtl/sbl_pkg.sv */
// Shared types, token codes and character classes for the source byte lexer.
`default_nettype none
package sbl_pkg;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_SLASH,
    MODE_EQ,
    MODE_ANGLE,
    MODE_WORD,
    MODE_NUM,
    MODE_COMMENT,
    MODE_CR
  } mode_e;

  localparam logic [5:0] KIND_UNKNOWN = 6'd0;
  localparam logic [5:0] KIND_DIV     = 6'd4;
  localparam logic [5:0] KIND_ASSIGN  = 6'd17;
  localparam logic [5:0] KIND_EQEQ    = 6'd18;
  localparam logic [5:0] KIND_ARROW   = 6'd19;
  localparam logic [5:0] KIND_LE      = 6'd20;
  localparam logic [5:0] KIND_GE      = 6'd21;
  localparam logic [5:0] KIND_LT      = 6'd22;
  localparam logic [5:0] KIND_GT      = 6'd23;
  localparam logic [5:0] KIND_INT     = 6'd24;
  localparam logic [5:0] KIND_FLT     = 6'd26;
  localparam logic [5:0] KIND_IDENT   = 6'd27;
  localparam logic [5:0] KIND_EOF     = 6'd39;

  localparam logic [19:0] POS_MAX = 20'hFFFFF;
  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  typedef struct packed {
    logic [5:0]  kind;
    logic [19:0] line;
    logic [19:0] column;
    logic [31:0] start;
    logic [15:0] length;
    logic [31:0] int_value;
    logic        dot_error;
    logic        eos;
  } result_t;

  function automatic logic is_letter(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic [5:0] single_kind(logic [7:0] b);
    logic [5:0] k;
    case (b)
      8'h2B: k = 6'd1;
      8'h2D: k = 6'd2;
      8'h2A: k = 6'd3;
      8'h5E: k = 6'd5;
      8'h26: k = 6'd6;
      8'h7B: k = 6'd7;
      8'h7D: k = 6'd8;
      8'h28: k = 6'd9;
      8'h29: k = 6'd10;
      8'h5B: k = 6'd11;
      8'h5D: k = 6'd12;
      8'h3B: k = 6'd13;
      8'h3A: k = 6'd14;
      8'h2E: k = 6'd15;
      8'h2C: k = 6'd16;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  // The window holds the first byte in the low octet, so names read reversed.
  function automatic logic [5:0] word_kind(logic [47:0] w, logic [15:0] run);
    logic [5:0] k;
    k = KIND_IDENT;
    if (run == 16'd6 && w[47:0] == "nruter") k = 6'd28;
    if (run == 16'd2 && w[15:0] == "fi")     k = 6'd29;
    if (run == 16'd4 && w[31:0] == "file")   k = 6'd30;
    if (run == 16'd4 && w[31:0] == "esle")   k = 6'd31;
    if (run == 16'd5 && w[39:0] == "elihw")  k = 6'd32;
    if (run == 16'd4 && w[31:0] == "corp")   k = 6'd33;
    if (run == 16'd6 && w[47:0] == "nretxe") k = 6'd34;
    if (run == 16'd3 && w[23:0] == "23u")    k = 6'd35;
    if (run == 16'd3 && w[23:0] == "23i")    k = 6'd36;
    if (run == 16'd2 && w[15:0] == "8i")     k = 6'd37;
    if (run == 16'd2 && w[15:0] == "8u")     k = 6'd38;
    return k;
  endfunction

endpackage
`default_nettype wire

/* rtl/sbl_result_fifo.sv */
// Four-entry token queue that takes up to three tokens per cycle and gives one.
`default_nettype none
module sbl_result_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [1:0]       push_cnt_i,
  input  sbl_pkg::result_t      push_data_i [3],
  input  wire logic             pop_i,
  output sbl_pkg::result_t      head_o,
  output logic                  not_empty_o,
  output logic                  room3_o
);

  sbl_pkg::result_t mem_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q;

  assign head_o      = mem_q[rd_ptr_q];
  assign not_empty_o = count_q != 3'd0;
  assign room3_o     = count_q <= 3'd1;

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      if (2'(j) < push_cnt_i) begin
        mem_q[wr_ptr_q + 2'(j)] <= push_data_i[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_cnt_i;
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      count_q <= count_q + {1'b0, push_cnt_i} - {2'b0, pop_i};
    end
  end

endmodule
`default_nettype wire

/* rtl/source_byte_lexer_top.sv */
// Top level of the source byte lexer: lexer state, token formation and output queue.
// Each accepted byte updates the lexer state and queues up to three tokens.
// Tokens are registered in the output queue; one token leaves per cycle while out_ready_i is high.
// A byte is taken in every cycle while at most one token is waiting in the queue.
// Reset is asynchronous and active low; it empties the queue and returns to line one.
`default_nettype none
module source_byte_lexer_top #(
  parameter int KEYWORD_MAX_LEN = 6,
  parameter int OFFSET_BITS     = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  char_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [5:0]       token_kind_o,
  output logic [19:0]      token_line_o,
  output logic [19:0]      token_column_o,
  output logic [31:0]      lexeme_start_o,
  output logic [15:0]      lexeme_length_o,
  output logic [31:0]      int_value_o,
  output logic             dot_error_o,
  output logic             end_of_stream_o
);

  sbl_pkg::mode_e          mode_q, mode_d;
  logic [OFFSET_BITS-1:0]  off_q, off_d, soff_q, soff_d;
  logic [19:0]             line_q, line_d, col_q, col_d, sline_q, sline_d, scol_q, scol_d;
  logic [15:0]             run_q, run_d;
  logic [31:0]             acc_q, acc_d;
  logic [1:0]              dots_q, dots_d;
  logic [7:0]              win_q [KEYWORD_MAX_LEN];
  logic [7:0]              win_d [KEYWORD_MAX_LEN];
  logic [5:0]              pk_q, pk_d;

  sbl_pkg::result_t        res_a [3];
  logic [1:0]              n_d;
  logic                    accept, body_flush, body_start;
  logic [7:0]              b;
  sbl_pkg::result_t        tmp;
  logic [47:0]             w6;
  sbl_pkg::result_t        head;
  logic                    room3;

  function automatic logic [47:0] pack6(input logic [7:0] w [KEYWORD_MAX_LEN]);
    logic [47:0] r;
    for (int i = 0; i < 6; i++) r[8*i +: 8] = w[i];
    return r;
  endfunction

  function automatic sbl_pkg::result_t pend(
    sbl_pkg::mode_e m, logic [5:0] pk, logic [19:0] sl, logic [19:0] sc,
    logic [OFFSET_BITS-1:0] so, logic [15:0] run, logic [31:0] acc,
    logic [1:0] dots, logic [47:0] w);
    sbl_pkg::result_t r;
    r = '0;
    r.line   = sl;
    r.column = sc;
    r.start  = 32'(so);
    r.length = 16'd1;
    case (m)
      sbl_pkg::MODE_SLASH: r.kind = sbl_pkg::KIND_DIV;
      sbl_pkg::MODE_WORD: begin
        r.kind   = sbl_pkg::word_kind(w, run);
        r.length = run;
      end
      sbl_pkg::MODE_NUM: begin
        r.kind      = pk;
        r.length    = run;
        r.int_value = (pk == sbl_pkg::KIND_INT) ? acc : 32'd0;
        r.dot_error = dots > 2'd1;
      end
      default: r.kind = pk;
    endcase
    return r;
  endfunction

  function automatic logic pending(sbl_pkg::mode_e m);
    return m == sbl_pkg::MODE_SLASH || m == sbl_pkg::MODE_EQ || m == sbl_pkg::MODE_ANGLE ||
           m == sbl_pkg::MODE_WORD || m == sbl_pkg::MODE_NUM;
  endfunction

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = room3;
  assign b          = char_byte_i;

  always_comb begin
    mode_d = mode_q; off_d = off_q; soff_d = soff_q;
    line_d = line_q; col_d = col_q; sline_d = sline_q; scol_d = scol_q;
    run_d = run_q; acc_d = acc_q; dots_d = dots_q; pk_d = pk_q;
    win_d = win_q;
    n_d = 2'd0;
    body_flush = 1'b0;
    body_start = 1'b0;
    tmp = '0;
    w6 = pack6(win_q);
    for (int j = 0; j < 3; j++) res_a[j] = '0;

    unique case (mode_q)
      sbl_pkg::MODE_SLASH: begin
        if (b == sbl_pkg::CH_SLASH) mode_d = sbl_pkg::MODE_COMMENT;
        else begin
          body_flush = 1'b1;
          body_start = 1'b1;
        end
      end
      sbl_pkg::MODE_EQ, sbl_pkg::MODE_ANGLE: begin
        if (b == sbl_pkg::CH_EQ || (mode_q == sbl_pkg::MODE_EQ && b == sbl_pkg::CH_GT)) begin
          tmp = pend(mode_q, pk_q, sline_q, scol_q, soff_q, 16'd2, acc_q, dots_q, w6);
          tmp.length = 16'd2;
          if (mode_q == sbl_pkg::MODE_EQ) begin
            tmp.kind = (b == sbl_pkg::CH_GT) ? sbl_pkg::KIND_ARROW : sbl_pkg::KIND_EQEQ;
          end else begin
            tmp.kind = (pk_q == sbl_pkg::KIND_LT) ? sbl_pkg::KIND_LE : sbl_pkg::KIND_GE;
          end
          res_a[n_d] = tmp;
          n_d = n_d + 2'd1;
          if (col_d != sbl_pkg::POS_MAX) col_d = col_d + 20'd1;
          mode_d = sbl_pkg::MODE_IDLE;
        end else begin
          body_flush = 1'b1;
          body_start = 1'b1;
        end
      end
      sbl_pkg::MODE_WORD: begin
        if (sbl_pkg::is_letter(b) || sbl_pkg::is_digit(b) || b == sbl_pkg::CH_UNDER) begin
          for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
            if (run_q == 16'(i)) win_d[i] = b;
          end
          if (run_d != sbl_pkg::LEN_MAX) run_d = run_d + 16'd1;
          if (col_d != sbl_pkg::POS_MAX) col_d = col_d + 20'd1;
        end else begin
          body_flush = 1'b1;
          body_start = 1'b1;
        end
      end
      sbl_pkg::MODE_NUM: begin
        if (sbl_pkg::is_digit(b)) begin
          acc_d = (acc_q << 3) + (acc_q << 1) + {24'd0, b - sbl_pkg::CH_ZERO};
          if (run_d != sbl_pkg::LEN_MAX) run_d = run_d + 16'd1;
          if (col_d != sbl_pkg::POS_MAX) col_d = col_d + 20'd1;
        end else if (b == sbl_pkg::CH_DOT) begin
          pk_d = sbl_pkg::KIND_FLT;
          if (dots_q < 2'd2) dots_d = dots_q + 2'd1;
          if (run_d != sbl_pkg::LEN_MAX) run_d = run_d + 16'd1;
          if (col_d != sbl_pkg::POS_MAX) col_d = col_d + 20'd1;
        end else begin
          body_flush = 1'b1;
          body_start = 1'b1;
        end
      end
      sbl_pkg::MODE_COMMENT: body_start = (b == sbl_pkg::CH_LF);
      sbl_pkg::MODE_CR: begin
        mode_d = sbl_pkg::MODE_IDLE;
        body_start = (b != sbl_pkg::CH_LF);
      end
      default: body_start = 1'b1;
    endcase

    if (body_flush) begin
      res_a[n_d] = pend(mode_q, pk_q, sline_q, scol_q, soff_q, run_q, acc_q, dots_q, w6);
      n_d = n_d + 2'd1;
      if (mode_q == sbl_pkg::MODE_SLASH && col_d != sbl_pkg::POS_MAX) col_d = col_d + 20'd1;
    end

    if (body_start) begin
      mode_d = sbl_pkg::MODE_IDLE;
      if (b == sbl_pkg::CH_LF || b == sbl_pkg::CH_CR) begin
        if (line_d != sbl_pkg::POS_MAX) line_d = line_d + 20'd1;
        col_d = 20'd1;
        if (b == sbl_pkg::CH_CR) mode_d = sbl_pkg::MODE_CR;
      end else if (b == sbl_pkg::CH_SPACE || b == sbl_pkg::CH_TAB) begin
        if (col_d != sbl_pkg::POS_MAX) col_d = col_d + 20'd1;
      end else begin
        soff_d  = off_q;
        sline_d = line_d;
        scol_d  = col_d;
        if (b == sbl_pkg::CH_SLASH) begin
          mode_d = sbl_pkg::MODE_SLASH;
        end else begin
          if (b == sbl_pkg::CH_EQ) begin
            pk_d   = sbl_pkg::KIND_ASSIGN;
            mode_d = sbl_pkg::MODE_EQ;
          end else if (b == sbl_pkg::CH_LT || b == sbl_pkg::CH_GT) begin
            pk_d   = (b == sbl_pkg::CH_LT) ? sbl_pkg::KIND_LT : sbl_pkg::KIND_GT;
            mode_d = sbl_pkg::MODE_ANGLE;
          end else if (sbl_pkg::is_letter(b) || b == sbl_pkg::CH_UNDER) begin
            win_d[0] = b;
            run_d    = 16'd1;
            mode_d   = sbl_pkg::MODE_WORD;
          end else if (sbl_pkg::is_digit(b)) begin
            acc_d  = {24'd0, b - sbl_pkg::CH_ZERO};
            dots_d = 2'd0;
            run_d  = 16'd1;
            pk_d   = sbl_pkg::KIND_INT;
            mode_d = sbl_pkg::MODE_NUM;
          end else begin
            tmp        = '0;
            tmp.kind   = sbl_pkg::single_kind(b);
            tmp.line   = sline_d;
            tmp.column = scol_d;
            tmp.start  = 32'(soff_d);
            tmp.length = 16'd1;
            res_a[n_d] = tmp;
            n_d = n_d + 2'd1;
          end
          if (col_d != sbl_pkg::POS_MAX) col_d = col_d + 20'd1;
        end
      end
    end

    off_d = off_q + OFFSET_BITS'(1);

    if (last_byte_i) begin
      if (pending(mode_d)) begin
        res_a[n_d] = pend(mode_d, pk_d, sline_d, scol_d, soff_d, run_d, acc_d, dots_d,
                          pack6(win_d));
        n_d = n_d + 2'd1;
      end
      tmp      = '0;
      tmp.kind = sbl_pkg::KIND_EOF;
      tmp.eos  = 1'b1;
      res_a[n_d] = tmp;
      n_d = n_d + 2'd1;
      mode_d = sbl_pkg::MODE_IDLE;
      off_d = '0; soff_d = '0;
      line_d = 20'd1; col_d = '0; sline_d = '0; scol_d = '0;
      run_d = '0; acc_d = '0; dots_d = '0; pk_d = '0;
      for (int i = 0; i < KEYWORD_MAX_LEN; i++) win_d[i] = '0;
    end

    if (!accept) n_d = 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= sbl_pkg::MODE_IDLE;
      off_q <= '0; soff_q <= '0;
      line_q <= 20'd1; col_q <= '0; sline_q <= '0; scol_q <= '0;
      run_q <= '0; acc_q <= '0; dots_q <= '0; pk_q <= '0;
      for (int i = 0; i < KEYWORD_MAX_LEN; i++) win_q[i] <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      off_q <= off_d; soff_q <= soff_d;
      line_q <= line_d; col_q <= col_d; sline_q <= sline_d; scol_q <= scol_d;
      run_q <= run_d; acc_q <= acc_d; dots_q <= dots_d; pk_q <= pk_d;
      win_q <= win_d;
    end
  end

  sbl_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (n_d),
    .push_data_i (res_a),
    .pop_i       (out_valid_o && out_ready_i),
    .head_o      (head),
    .not_empty_o (out_valid_o),
    .room3_o     (room3)
  );

  assign token_kind_o    = head.kind;
  assign token_line_o    = head.line;
  assign token_column_o  = head.column;
  assign lexeme_start_o  = head.start;
  assign lexeme_length_o = head.length;
  assign int_value_o     = head.int_value;
  assign dot_error_o     = head.dot_error;
  assign end_of_stream_o = head.eos;

endmodule
`default_nettype wire
